>>> rtl/core/tcw_pkg.sv
// shared constants and types for the text console cell writer
package tcw_pkg;

   // screen geometry defaults
   localparam int ROWS_DEF = 22;
   localparam int COLS_DEF = 72;

   // field widths fixed by the stream formats
   localparam int FUNC_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int COLOR_W = 32;
   localparam int ROWF_W  = 5;
   localparam int COLF_W  = 7;
   localparam int DATA_W  = 56;

   // function codes
   localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   // special characters
   localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [BYTE_W-1:0] CH_SPACE     = 8'd32;

   // reset value of the default row color
   localparam logic [COLOR_W-1:0] COLOR_RESET = 32'hFF00FF88;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_ZERO,
      S_RDATA,
      S_SCROLL,
      S_CLR,
      S_DONE
   } state_type;

endpackage

>>> rtl/core/tcw_ram.sv
// generic single write port ram with registered read
module tcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/text_console_cell_writer_core.sv
// text console top level: cell memory, row color memory, cursor and scroll control
//
// A character-cell console of ROWS x COLS bytes with one color per row and a
// cursor. Each request (tuser = function code) returns exactly one response.
// A put or a read passes the exec and done states (a read in range also the rdata
// state) before its response; a put that writes into a row blanked by reset,
// scroll or clear first zeroes that row in the zero state, through the single
// write port of the cell memory; a put that scrolls adds the scroll state.
// Scroll does not move any cells: logical rows map to physical rows through a
// rotating base, and a per-row valid bit makes a freshly scrolled-in row read as
// zeros until it is written. A clear request walks the row color memory, one row
// a cycle. After reset the same color sweep runs and no request is accepted
// until it ends; csr writes are taken at any time.
module text_console_cell_writer_core #(
   parameter int ROWS = tcw_pkg::ROWS_DEF,
   parameter int COLS = tcw_pkg::COLS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // char_code[7:0], char_color[39:8], read_row[44:40], read_col[51:45], zero fill
   input  logic [tcw_pkg::DATA_W-1:0]  req_tdata,
   // func[1:0]
   input  logic [tcw_pkg::FUNC_W-1:0]  req_tuser,
   // response channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // cell_byte[7:0], row_color[39:8], cursor_row[44:40], cursor_col[51:45],
   // scrolled[52], zero fill
   output logic [tcw_pkg::DATA_W-1:0]  rsp_tdata,
   // default color register write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [tcw_pkg::COLOR_W-1:0] csr_data
);

   import tcw_pkg::*;

   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLS);
   localparam int AW    = $clog2(ROWS * COLS);
   localparam int CNT_W = (CW > RW) ? CW : RW;

   // state registers
   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   clr_reply_ff, clr_reply_in;
   logic [RW-1:0]          cursor_y_ff, cursor_y_in;
   logic [CW-1:0]          cursor_x_ff, cursor_x_in;
   logic [RW-1:0]          base_ff, base_in;
   logic [ROWS-1:0]        row_valid_ff, row_valid_in;
   logic [COLOR_W-1:0]     default_color_ff, default_color_in;
   logic [COLOR_W-1:0]     sweep_color_ff, sweep_color_in;

   // latched request
   logic [FUNC_W-1:0]      func_ff, func_in;
   logic [BYTE_W-1:0]      code_ff, code_in;
   logic [COLOR_W-1:0]     color_ff, color_in;
   logic [ROWF_W-1:0]      rrow_ff, rrow_in;
   logic [COLF_W-1:0]      rcol_ff, rcol_in;

   // result being built
   logic [BYTE_W-1:0]      res_cell_ff, res_cell_in;
   logic [COLOR_W-1:0]     res_color_ff, res_color_in;
   logic                   res_scr_ff, res_scr_in;
   logic [RW-1:0]          rd_phys_ff, rd_phys_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]      rsp_data_ff, rsp_data_in;

   // memory ports
   logic                   cell_we;
   logic [AW-1:0]          cell_waddr;
   logic [BYTE_W-1:0]      cell_wdata;
   logic [AW-1:0]          cell_raddr;
   logic [BYTE_W-1:0]      cell_q;
   logic                   color_we;
   logic [RW-1:0]          color_waddr;
   logic [COLOR_W-1:0]     color_wdata;
   logic [RW-1:0]          color_raddr;
   logic [COLOR_W-1:0]     color_q;

   // decode helpers
   logic [RW-1:0]          cur_phys;
   logic [RW-1:0]          rd_phys;
   logic                   rd_in_range;
   logic                   is_nl;
   logic                   is_bs;
   logic                   writes_cell;
   logic                   req_accept;

   // logical row to physical row through the scroll base
   function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] y,
                                               input logic [RW-1:0] base);
      logic [RW:0] sum;
      sum = {1'b0, y} + {1'b0, base};
      if (sum >= (RW+1)'(ROWS)) begin
         sum = sum - (RW+1)'(ROWS);
      end
      return sum[RW-1:0];
   endfunction

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                                input logic [CW-1:0] col);
      return AW'(prow) * AW'(COLS) + AW'(col);
   endfunction

   tcw_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (ROWS * COLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cell_waddr),
      .wr_data (cell_wdata),
      .rd_addr (cell_raddr),
      .rd_data (cell_q)
   );

   tcw_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (ROWS)
   ) u_color_ram (
      .clock   (clock),
      .wr_en   (color_we),
      .wr_addr (color_waddr),
      .wr_data (color_wdata),
      .rd_addr (color_raddr),
      .rd_data (color_q)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign cur_phys    = phys_row(cursor_y_ff, base_ff);
   assign rd_in_range = (int'(rrow_ff) < ROWS) && (int'(rcol_ff) < COLS);
   assign rd_phys     = phys_row(RW'(rrow_ff), base_ff);
   assign is_nl       = (code_ff == CH_NEWLINE);
   assign is_bs       = (code_ff == CH_BACKSPACE);
   // newline recolors without writing a cell; backspace at column zero is a no-op
   assign writes_cell = !is_nl && !(is_bs && (cursor_x_ff == '0));

   // read addresses only matter in the exec cycle of a read
   assign cell_raddr  = cell_addr(rd_phys, CW'(rcol_ff));
   assign color_raddr = rd_phys;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLR;
         count_ff         <= '0;
         clr_reply_ff     <= 1'b0;
         cursor_y_ff      <= '0;
         cursor_x_ff      <= '0;
         base_ff          <= '0;
         row_valid_ff     <= '0;
         default_color_ff <= COLOR_RESET;
         sweep_color_ff   <= COLOR_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         count_ff         <= count_in;
         clr_reply_ff     <= clr_reply_in;
         cursor_y_ff      <= cursor_y_in;
         cursor_x_ff      <= cursor_x_in;
         base_ff          <= base_in;
         row_valid_ff     <= row_valid_in;
         default_color_ff <= default_color_in;
         sweep_color_ff   <= sweep_color_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      code_ff      <= code_in;
      color_ff     <= color_in;
      rrow_ff      <= rrow_in;
      rcol_ff      <= rcol_in;
      res_cell_ff  <= res_cell_in;
      res_color_ff <= res_color_in;
      res_scr_ff   <= res_scr_in;
      rd_phys_ff   <= rd_phys_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      clr_reply_in     = clr_reply_ff;
      cursor_y_in      = cursor_y_ff;
      cursor_x_in      = cursor_x_ff;
      base_in          = base_ff;
      row_valid_in     = row_valid_ff;
      default_color_in = default_color_ff;
      sweep_color_in   = sweep_color_ff;
      func_in          = func_ff;
      code_in          = code_ff;
      color_in         = color_ff;
      rrow_in          = rrow_ff;
      rcol_in          = rcol_ff;
      res_cell_in      = res_cell_ff;
      res_color_in     = res_color_ff;
      res_scr_in       = res_scr_ff;
      rd_phys_in       = rd_phys_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;

      cell_we     = 1'b0;
      cell_waddr  = cell_addr(cur_phys, cursor_x_ff);
      cell_wdata  = code_ff;
      color_we    = 1'b0;
      color_waddr = cur_phys;
      color_wdata = color_ff;

      if (csr_valid) begin
         default_color_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               func_in  = req_tuser;
               code_in  = req_tdata[7:0];
               color_in = req_tdata[39:8];
               rrow_in  = req_tdata[44:40];
               rcol_in  = req_tdata[51:45];
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            res_cell_in  = '0;
            res_color_in = '0;
            res_scr_in   = 1'b0;
            state_in     = S_DONE;
            case (func_ff)
               FUNC_PUT: begin
                  if (writes_cell && !row_valid_ff[cur_phys]) begin
                     // blank row: zero it before the first write lands
                     count_in = '0;
                     state_in = S_ZERO;
                  end else begin
                     if (is_bs) begin
                        if (cursor_x_ff != '0) begin
                           cell_we     = 1'b1;
                           cell_waddr  = cell_addr(cur_phys, cursor_x_ff - 1'b1);
                           cell_wdata  = CH_SPACE;
                           cursor_x_in = cursor_x_ff - 1'b1;
                        end
                     end else begin
                        color_we = 1'b1;
                        if (!is_nl) begin
                           cell_we = 1'b1;
                        end
                        if (is_nl || (cursor_x_ff == CW'(COLS - 1))) begin
                           // move to the start of the next row
                           cursor_x_in = '0;
                           if (cursor_y_ff == RW'(ROWS - 1)) begin
                              res_scr_in = 1'b1;
                              state_in   = S_SCROLL;
                           end else begin
                              cursor_y_in = cursor_y_ff + 1'b1;
                           end
                        end else begin
                           cursor_x_in = cursor_x_ff + 1'b1;
                        end
                     end
                  end
               end
               FUNC_READ: begin
                  if (rd_in_range) begin
                     rd_phys_in = rd_phys;
                     state_in   = S_RDATA;
                  end
               end
               FUNC_CLEAR: begin
                  row_valid_in   = '0;
                  base_in        = '0;
                  cursor_y_in    = '0;
                  cursor_x_in    = '0;
                  sweep_color_in = default_color_ff;
                  count_in       = '0;
                  clr_reply_in   = 1'b1;
                  state_in       = S_CLR;
               end
               default: begin
                  // unused function code: cursor only
               end
            endcase
         end

         S_ZERO: begin
            cell_we    = 1'b1;
            cell_waddr = cell_addr(cur_phys, count_ff[CW-1:0]);
            cell_wdata = '0;
            if (count_ff == CNT_W'(COLS - 1)) begin
               row_valid_in[cur_phys] = 1'b1;
               state_in               = S_EXEC;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end

         S_RDATA: begin
            res_cell_in  = row_valid_ff[rd_phys_ff] ? cell_q : '0;
            res_color_in = color_q;
            state_in     = S_DONE;
         end

         S_SCROLL: begin
            // the oldest physical row becomes the new bottom row
            color_we              = 1'b1;
            color_waddr           = base_ff;
            color_wdata           = default_color_ff;
            row_valid_in[base_ff] = 1'b0;
            base_in  = (base_ff == RW'(ROWS - 1)) ? '0 : base_ff + 1'b1;
            state_in = S_DONE;
         end

         S_CLR: begin
            color_we    = 1'b1;
            color_waddr = count_ff[RW-1:0];
            color_wdata = sweep_color_ff;
            if (count_ff == CNT_W'(ROWS - 1)) begin
               state_in = clr_reply_ff ? S_DONE : S_IDLE;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, res_scr_ff, COLF_W'(cursor_x_ff),
                               ROWF_W'(cursor_y_ff), res_color_ff, res_cell_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   // cursor never leaves the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (int'(cursor_y_ff) < ROWS) && (int'(cursor_x_ff) < COLS))
      else $error("cursor out of screen");

   // color sweep blocks new requests
   a_sweep_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR) |-> !req_tready)
      else $error("request accepted during color sweep");

   // an accepted request is decoded in the next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_EXEC))
      else $error("accepted request not executed");

   // cells are only written into rows that were zeroed
   a_write_valid_row: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_EXEC) && cell_we) |-> row_valid_ff[cur_phys])
      else $error("cell write into blank row");
`endif

endmodule

>>> sim/tb_top.sv
// testbench for the text console cell writer: directed table, then random put/read/clear traffic
`timescale 1ns / 100ps

module tb_top;
   import tcw_pkg::*;

   localparam int ROWS = ROWS_DEF;
   localparam int COLS = COLS_DEF;
   // cycles without any handshake before the run is called hung
   localparam int STALL_LIMIT = 2000;
   // cycles of quiet after the last response
   localparam int TAIL_CYCLES = 100;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [BYTE_W-1:0]  code;
      logic [COLOR_W-1:0] color;
      logic [ROWF_W-1:0]  row;
      logic [COLF_W-1:0]  col;
   } console_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  cell_byte;
      logic [COLOR_W-1:0] row_color;
      logic [ROWF_W-1:0]  cursor_row;
      logic [COLF_W-1:0]  cursor_col;
      logic               scrolled;
   } console_rsp_type;

   typedef struct packed {
      console_req_type rq;
      logic            typed;
      console_rsp_type rsp;
   } directed_row_type;

   localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_W-1:0]    req_tdata = '0;
   logic [FUNC_W-1:0]    req_tuser = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_W-1:0]    rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [COLOR_W-1:0]   csr_data = '0;

   // screen image kept by the testbench
   logic [BYTE_W-1:0]    screen [0:ROWS-1][0:COLS-1];
   logic [COLOR_W-1:0]   line_color [0:ROWS-1];
   int                   cur_row;
   int                   cur_col;
   logic [COLOR_W-1:0]   default_color;

   console_rsp_type      awaited_rsp [$];
   directed_row_type     directed_rows [$];

   logic                 steady = 1'b0;   // no idling on either side while set
   int                   errors = 0;
   int                   quiet_cycles = 0;
   int                   n_requests = 0;
   int                   n_scrolls = 0;
   int                   n_clears = 0;
   int                   n_oob_reads = 0;
   int                   n_checked = 0;

   text_console_cell_writer_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- screen image

   function automatic void clear_screen();
      int r, c;
      for (r = 0; r < ROWS; r++) begin
         for (c = 0; c < COLS; c++)
            screen[r][c] = '0;
         line_color[r] = default_color;
      end
      cur_row = 0;
      cur_col = 0;
   endfunction

   // cursor to column 0 of the next row; past the bottom the screen moves up one row
   function automatic logic advance_row();
      int r, c;
      cur_col = 0;
      cur_row++;
      if (cur_row < ROWS)
         return 1'b0;
      for (r = 0; r < ROWS - 1; r++) begin
         for (c = 0; c < COLS; c++)
            screen[r][c] = screen[r+1][c];
         line_color[r] = line_color[r+1];
      end
      for (c = 0; c < COLS; c++)
         screen[ROWS-1][c] = '0;
      line_color[ROWS-1] = default_color;
      cur_row = ROWS - 1;
      return 1'b1;
   endfunction

   function automatic console_rsp_type apply_to_screen(input console_req_type rq);
      console_rsp_type rs;
      rs = '0;
      case (rq.func)
         FUNC_PUT: begin
            if (rq.code == CH_NEWLINE) begin
               line_color[cur_row] = rq.color;
               rs.scrolled = advance_row();
            end else if (rq.code == CH_BACKSPACE) begin
               // at column 0 nothing moves and the row keeps its color
               if (cur_col > 0) begin
                  cur_col--;
                  screen[cur_row][cur_col] = CH_SPACE;
               end
            end else begin
               screen[cur_row][cur_col] = rq.code;
               line_color[cur_row] = rq.color;
               cur_col++;
               if (cur_col >= COLS)
                  rs.scrolled = advance_row();
            end
         end
         FUNC_READ: begin
            if (rq.row < ROWS && rq.col < COLS) begin
               rs.cell_byte = screen[rq.row][rq.col];
               rs.row_color = line_color[rq.row];
            end
         end
         FUNC_CLEAR: clear_screen();
         default: ;   // unused code leaves the screen alone
      endcase
      rs.cursor_row = cur_row[ROWF_W-1:0];
      rs.cursor_col = cur_col[COLF_W-1:0];
      return rs;
   endfunction

   // ---------------------------------------------------------------- request side

   task automatic send_request(input console_req_type rq, input logic typed,
                               input console_rsp_type typed_rsp);
      console_rsp_type predicted;
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 6) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= rq.func;
      req_tdata  <= {4'b0000, rq.col, rq.row, rq.color, rq.code};
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = apply_to_screen(rq);
      awaited_rsp.push_back(typed ? typed_rsp : predicted);
      n_requests++;
      if (predicted.scrolled)
         n_scrolls++;
      if (rq.func == FUNC_CLEAR)
         n_clears++;
      if (rq.func == FUNC_READ && (rq.row >= ROWS || rq.col >= COLS))
         n_oob_reads++;
   endtask

   // drop the request, let every response come home, then wait a little longer
   task automatic settle(input int extra);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_rsp.size() != 0)
         @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_default_color(input logic [COLOR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      default_color = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void add_row(input logic [FUNC_W-1:0] func, input logic [7:0] code,
                                   input logic [31:0] color, input logic [4:0] row,
                                   input logic [6:0] col, input logic typed,
                                   input logic [31:0] exp_color);
      directed_row_type d;
      d.rq.func  = func;
      d.rq.code  = code;
      d.rq.color = color;
      d.rq.row   = row;
      d.rq.col   = col;
      d.typed    = typed;
      // typed rows all leave the cursor at the origin and read a blank cell
      d.rsp      = '0;
      d.rsp.row_color = exp_color;
      directed_rows.push_back(d);
   endfunction

   function automatic logic [COLOR_W-1:0] random_color();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick == 0)
         return '0;
      if (pick == 1)
         return '1;
      return $urandom;
   endfunction

   // mostly text lines with reads mixed in; nl_weight sets how often a line ends
   function automatic console_req_type random_request(input int nl_weight);
      console_req_type rq;
      int pick, sub;
      pick = $urandom_range(0, 999);
      sub  = $urandom_range(0, 9);
      rq.code  = BYTE_W'($urandom_range(0, 255));
      rq.color = random_color();
      rq.row   = ROWF_W'($urandom_range(0, 31));
      rq.col   = COLF_W'($urandom_range(0, 127));
      if (pick < 3) begin
         rq.func = FUNC_CLEAR;
      end else if (pick < 15) begin
         rq.func = FUNC_NONE;
      end else if (pick < 265) begin
         rq.func = FUNC_READ;
         if (sub != 0) begin
            // in range: the cursor row, the bottom row, or anywhere
            if (sub < 5)
               rq.row = ROWF_W'(cur_row);
            else if (sub < 7)
               rq.row = ROWF_W'(ROWS - 1);
            else
               rq.row = ROWF_W'($urandom_range(0, ROWS - 1));
            if ($urandom_range(0, 1) == 0)
               rq.col = COLF_W'($urandom_range(0, cur_col));
            else
               rq.col = COLF_W'($urandom_range(0, COLS - 1));
         end
      end else if (pick < 265 + nl_weight) begin
         rq.func = FUNC_PUT;
         rq.code = CH_NEWLINE;
      end else if (pick < 325 + nl_weight) begin
         rq.func = FUNC_PUT;
         rq.code = CH_BACKSPACE;
      end else begin
         rq.func = FUNC_PUT;
      end
      return rq;
   endfunction

   task automatic run_random(input int count, input int nl_weight);
      console_req_type rq;
      int done_items;
      done_items = 0;
      while (done_items < count) begin
         rq = random_request(nl_weight);
         send_request(rq, 1'b0, '0);
         if (rq.func != FUNC_NONE)
            done_items++;
      end
   endtask

   // ---------------------------------------------------------------- response side

   always @(negedge clock)
      rsp_tready <= steady || ($urandom_range(0, 99) >= 6);

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      console_rsp_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (awaited_rsp.size() == 0) begin
            errors++;
            $display("%0t: response with nothing awaited, expected none actual %h",
                     $time, rsp_tdata);
         end else begin
            want = awaited_rsp.pop_front();
            n_checked++;
            check_field("cell_byte",  32'(want.cell_byte),  32'(rsp_tdata[7:0]));
            check_field("row_color",  want.row_color,       rsp_tdata[39:8]);
            check_field("cursor_row", 32'(want.cursor_row), 32'(rsp_tdata[44:40]));
            check_field("cursor_col", 32'(want.cursor_col), 32'(rsp_tdata[51:45]));
            check_field("scrolled",   32'(want.scrolled),   32'(rsp_tdata[52]));
         end
      end
   end

   // watchdog on handshakes of any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready) ||
          (csr_valid && csr_ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
                  $time, quiet_cycles, awaited_rsp.size());
         $display("tb_top NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      logic [COLOR_W-1:0] phase_color [0:4];
      int nl_weight [0:4];
      int i;
      default_color = COLOR_RESET;
      clear_screen();

      phase_color[0] = '1;
      phase_color[1] = '0;
      phase_color[2] = $urandom;
      phase_color[3] = $urandom;
      phase_color[4] = 32'h8000_0001;
      // long lines in phase 1 give wraps, short ones elsewhere give scrolls
      nl_weight[0] = 150;
      nl_weight[1] = 8;
      nl_weight[2] = 100;
      nl_weight[3] = 30;
      nl_weight[4] = 60;

      // fresh screen: blank cells, reset row color, out-of-range reads, ignored code
      add_row(FUNC_READ,  8'h00, 32'h0,         5'd0,  7'd0,   1'b1, COLOR_RESET);
      add_row(FUNC_READ,  8'hFF, 32'hFFFFFFFF,  5'd21, 7'd71,  1'b1, COLOR_RESET);
      add_row(FUNC_READ,  8'h00, 32'h0,         5'd22, 7'd0,   1'b1, '0);
      add_row(FUNC_READ,  8'hFF, 32'hFFFFFFFF,  5'd31, 7'd127, 1'b1, '0);
      add_row(FUNC_READ,  8'h00, 32'h0,         5'd0,  7'd72,  1'b1, '0);
      add_row(FUNC_NONE,  8'hFF, 32'hFFFFFFFF,  5'd31, 7'd127, 1'b1, '0);
      // backspace at column 0 does nothing
      add_row(FUNC_PUT,   CH_BACKSPACE, 32'hFFFFFFFF, 5'd0, 7'd0, 1'b1, '0);
      // plain bytes, zero byte included, then backspace, readback, newline and a write on the next row
      add_row(FUNC_PUT,   8'h41, 32'h0,         5'd0,  7'd0,   1'b0, '0);
      add_row(FUNC_PUT,   8'hFF, 32'hFFFFFFFF,  5'd31, 7'd127, 1'b0, '0);
      add_row(FUNC_PUT,   8'h00, 32'h12345678,  5'd0,  7'd0,   1'b0, '0);
      add_row(FUNC_PUT,   CH_BACKSPACE, 32'hDEADBEEF, 5'd0, 7'd0, 1'b0, '0);
      add_row(FUNC_READ,  8'h00, 32'h0,         5'd0,  7'd2,   1'b0, '0);
      add_row(FUNC_READ,  8'h00, 32'h0,         5'd0,  7'd0,   1'b0, '0);
      add_row(FUNC_PUT,   CH_NEWLINE, 32'hA5A5A5A5, 5'd0, 7'd0, 1'b0, '0);
      add_row(FUNC_READ,  8'h00, 32'h0,         5'd0,  7'd1,   1'b0, '0);
      add_row(FUNC_PUT,   8'h7F, 32'h5A5A5A5A,  5'd0,  7'd0,   1'b0, '0);
      add_row(FUNC_READ,  8'h00, 32'h0,         5'd1,  7'd0,   1'b0, '0);
      add_row(FUNC_READ,  8'h00, 32'h0,         5'd21, 7'd0,   1'b0, '0);
      // clear brings back the blank screen
      add_row(FUNC_CLEAR, 8'hFF, 32'hFFFFFFFF,  5'd31, 7'd127, 1'b1, '0);
      add_row(FUNC_READ,  8'h00, 32'h0,         5'd0,  7'd0,   1'b1, COLOR_RESET);
      add_row(FUNC_READ,  8'h00, 32'h0,         5'd1,  7'd0,   1'b1, COLOR_RESET);

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k])
         send_request(directed_rows[k].rq, directed_rows[k].typed, directed_rows[k].rsp);

      for (i = 0; i < 5; i++) begin
         settle(8);
         write_default_color(phase_color[i]);
         steady = (i == 2);
         run_random(330, nl_weight[i]);
      end
      steady = 1'b0;

      settle(TAIL_CYCLES);

      $display("%0d requests, %0d responses checked, %0d scrolls, %0d clears",
               n_requests, n_checked, n_scrolls, n_clears);
      $display("%0d out-of-range reads, 6 default colors, %0d failures",
               n_oob_reads, errors);
      if (errors == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
